// ----- rtl/assert_macros.svh -----
// assertion helpers shared by cdbt_fifo and cdbt_front
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion violated");

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/cdbt_pkg.sv -----
package cdbt_pkg;

  // sector buffer depth in words
  localparam int unsigned BUF_WORDS = 8192;
  localparam int unsigned BUF_IDX_W = 13;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XFER_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SRC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COUNT = 3'd4;

  // operations
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // destination codes
  localparam logic [2:0] DEST_HOST_A = 3'd2;
  localparam logic [2:0] DEST_HOST_B = 3'd3;
  localparam logic [2:0] DEST_PCM    = 3'd4;
  localparam logic [2:0] DEST_PRG    = 3'd5;
  localparam logic [2:0] DEST_WORD   = 3'd7;

  // write targets
  localparam logic [1:0] TGT_PCM  = 2'd0;
  localparam logic [1:0] TGT_PRG  = 2'd1;
  localparam logic [1:0] TGT_WORD = 2'd2;

  localparam logic [15:0] NOT_READY_VALUE = 16'hffff;

  // one classified item as it waits for the back end
  typedef struct packed {
    logic                 pcm;
    logic                 write_valid;
    logic [1:0]           write_target;
    logic [19:0]          write_address;
    logic [15:0]          write_data;
    logic [15:0]          read_value;
    logic [BUF_IDX_W-1:0] buffer_index;
    logic                 running;
    logic                 host_ready;
    logic                 done_flag;
    logic                 irq_pending;
  } cdbt_rec_t;

endpackage

// ----- rtl/cdbt_if.sv -----
interface cdbt_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] buffer_word;

  modport source (output valid, output operation, output buffer_word, input ready);
  modport sink (input valid, input operation, input buffer_word, output ready);
endinterface

interface cdbt_result_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [1:0]  write_target;
  logic [19:0] write_address;
  logic [15:0] write_data;
  logic [15:0] read_value;
  logic [12:0] buffer_index;
  logic        running;
  logic        host_ready;
  logic        done_flag;
  logic        irq_pending;
  logic        last;

  modport source (
    output valid, output write_valid, output write_target, output write_address,
    output write_data, output read_value, output buffer_index, output running,
    output host_ready, output done_flag, output irq_pending, output last,
    input ready
  );
  modport sink (
    input valid, input write_valid, input write_target, input write_address,
    input write_data, input read_value, input buffer_index, input running,
    input host_ready, input done_flag, input irq_pending, input last,
    output ready
  );
endinterface

// ----- rtl/cdbt_fifo.sv -----
`include "assert_macros.svh"

module cdbt_fifo import cdbt_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cdbt_rec_t push_rec,
  input  logic      pop,
  output cdbt_rec_t head,
  output logic      empty,
  output logic      full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cdbt_rec_t     entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `ASSERT_IMPLY(a_no_pop_empty, clk, rst, pop, !empty)
  `ASSERT_IMPLY(a_no_push_full, clk, rst, push, !full)

endmodule

// ----- rtl/cdbt_front.sv -----
`include "assert_macros.svh"

module cdbt_front import cdbt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cdbt_item_if.sink             items,
  input  logic                  queue_full,
  output logic                  push,
  output cdbt_rec_t             rec
);

  // configuration
  logic [2:0]  dest_mode;
  logic        xfer_enable;
  logic [15:0] start_source;
  logic [18:0] start_dest_addr;
  logic [15:0] start_count;

  // transfer state
  logic        run_flag, run_flag_next;
  logic        ready_flag, ready_flag_next;
  logic        done_bit, done_bit_next;
  logic        irq_bit, irq_bit_next;
  logic [15:0] src_offset, src_offset_next;
  logic [18:0] dst_address, dst_address_next;
  logic [15:0] count_left, count_left_next;

  logic fire;
  logic dma_dest;
  logic is_pcm;
  logic do_advance;

  assign items.ready = !queue_full;
  assign fire        = items.valid && items.ready;
  assign push        = fire;

  assign is_pcm   = (dest_mode == DEST_PCM);
  assign dma_dest = is_pcm || (dest_mode == DEST_PRG) || (dest_mode == DEST_WORD);

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_mode       <= '0;
      xfer_enable     <= 1'b0;
      start_source    <= '0;
      start_dest_addr <= '0;
      start_count     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEST_MODE:   dest_mode       <= cfg_data[2:0];
        CFG_XFER_ENABLE: xfer_enable     <= cfg_data[0];
        CFG_START_SRC:   start_source    <= cfg_data[15:0];
        CFG_START_DST:   start_dest_addr <= cfg_data[18:0];
        CFG_START_COUNT: start_count     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    run_flag_next    = run_flag;
    ready_flag_next  = ready_flag;
    done_bit_next    = done_bit;
    irq_bit_next     = irq_bit;
    src_offset_next  = src_offset;
    dst_address_next = dst_address;
    count_left_next  = count_left;
    do_advance       = 1'b0;
    rec              = '0;

    unique case (items.operation)
      OP_START: begin
        if (xfer_enable) begin
          src_offset_next  = start_source;
          dst_address_next = start_dest_addr;
          count_left_next  = start_count;
          run_flag_next    = 1'b1;
          ready_flag_next  = (dest_mode == DEST_HOST_A) || (dest_mode == DEST_HOST_B);
          done_bit_next    = 1'b0;
          irq_bit_next     = 1'b0;
        end
      end
      OP_STEP: begin
        if (run_flag && dma_dest) begin
          rec.write_valid = 1'b1;
          rec.write_data  = items.buffer_word;
          do_advance      = 1'b1;
          if (is_pcm) begin
            // byte pair into pcm ram window, low bit set by back end
            rec.pcm           = 1'b1;
            rec.write_target  = TGT_PCM;
            rec.write_address = {7'd0, 1'b1, dst_address[12:1]};
            dst_address_next  = dst_address + 19'd4;
          end else if (dest_mode == DEST_PRG) begin
            rec.write_target  = TGT_PRG;
            rec.write_address = {1'b0, dst_address[18:1], 1'b0};
            dst_address_next  = dst_address + 19'd2;
          end else begin
            rec.write_target  = TGT_WORD;
            rec.write_address = {2'b10, dst_address[17:1], 1'b0};
            dst_address_next  = dst_address + 19'd2;
          end
        end
      end
      OP_READ: begin
        if (!ready_flag) begin
          rec.read_value = NOT_READY_VALUE;
        end else begin
          rec.read_value = items.buffer_word;
          do_advance     = 1'b1;
        end
      end
      OP_STOP: begin
        run_flag_next   = 1'b0;
        ready_flag_next = 1'b0;
      end
      default: ;
    endcase

    if (do_advance) begin
      src_offset_next = src_offset + 16'd2;
      // transfer ends when zero or one remains before the decrement by two
      if (count_left == 16'd0 || count_left == 16'd1) begin
        run_flag_next   = 1'b0;
        ready_flag_next = 1'b0;
        done_bit_next   = 1'b1;
        irq_bit_next    = 1'b1;
      end
      count_left_next = count_left - 16'd2;
    end

    rec.buffer_index = BUF_IDX_W'((src_offset_next >> 1) % BUF_WORDS);
    rec.running      = run_flag_next;
    rec.host_ready   = ready_flag_next;
    rec.done_flag    = done_bit_next;
    rec.irq_pending  = irq_bit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag    <= 1'b0;
      ready_flag  <= 1'b0;
      done_bit    <= 1'b0;
      irq_bit     <= 1'b0;
      src_offset  <= '0;
      dst_address <= '0;
      count_left  <= '0;
    end else if (fire) begin
      run_flag    <= run_flag_next;
      ready_flag  <= ready_flag_next;
      done_bit    <= done_bit_next;
      irq_bit     <= irq_bit_next;
      src_offset  <= src_offset_next;
      dst_address <= dst_address_next;
      count_left  <= count_left_next;
    end
  end

  `ASSERT_IMPLY(a_ready_needs_run, clk, rst, ready_flag, run_flag)
  `ASSERT_ALWAYS(a_run_done_excl, clk, rst, !(run_flag && done_bit))

endmodule

// ----- rtl/cdbt_back.sv -----
module cdbt_back import cdbt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cdbt_rec_t head,
  input  logic      empty,
  output logic      pop,
  cdbt_result_if.source results
);

  // set while the high byte of a pcm pair has gone and the low byte waits
  logic phase;
  logic fire;

  assign results.valid = !empty;
  assign fire          = results.valid && results.ready;
  assign pop           = fire && (!head.pcm || phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (fire && head.pcm) begin
      phase <= !phase;
    end
  end

  always_comb begin
    results.write_valid   = head.write_valid;
    results.write_target  = head.write_target;
    results.write_address = head.write_address;
    results.write_data    = head.write_data;
    results.read_value    = head.read_value;
    results.buffer_index  = head.buffer_index;
    results.running       = head.running;
    results.host_ready    = head.host_ready;
    results.done_flag     = head.done_flag;
    results.irq_pending   = head.irq_pending;
    results.last          = 1'b1;
    if (head.pcm) begin
      if (!phase) begin
        results.write_address = head.write_address | 20'd1;
        results.write_data    = {8'd0, head.write_data[15:8]};
        results.last          = 1'b0;
      end else begin
        results.write_data    = {8'd0, head.write_data[7:0]};
      end
    end
  end

endmodule

// ----- rtl/cd_buffer_transfer_dma.sv -----
// channel   dir  handshake      payload
// items     in   valid/ready    operation, buffer_word
// results   out  valid/ready    write_*, read_value, buffer_index, status flags, last
// cfg       in   cfg_write      cfg_index, cfg_data (no read-back)
//
// one beat per cycle on results while results.ready is high; a pcm dma step makes two beats, everything else one
// an item is classified the cycle it is taken and is registered in the queue before its first beat can leave
// sustained rate: one item per cycle while results are accepted, a pcm step taking two beats on the single result port
// rst is synchronous, active high; clears config, transfer state and the queue
// items stall only when the queue is full; a results stall blocks classification only once the queue fills

module cd_buffer_transfer_dma import cdbt_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cdbt_item_if.sink             items,
  cdbt_result_if.source         results
);

  // classified record handed from front to back
  cdbt_rec_t push_rec;
  cdbt_rec_t head;
  logic      push;
  logic      pop;
  logic      empty;
  logic      full;

  // front: config registers, transfer state, per-item classification
  cdbt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .items      (items),
    .queue_full (full),
    .push       (push),
    .rec        (push_rec)
  );

  // short queue so front and back stall independently
  cdbt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // back: splits pcm steps into a byte pair, drives result beats
  cdbt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .results (results)
  );

endmodule
